### rtl/core/csa_pkg.sv
`timescale 1ns / 1ps

package csa_pkg;

    localparam int DataWidth = 64;

    typedef enum logic [2:0] {
        OP_ADD = 3'd0,
        OP_SUB = 3'd1,
        OP_MUL = 3'd2,
        OP_DIV = 3'd3,
        OP_MOD = 3'd4
    } op_t;

    typedef enum logic [2:0] {
        ST_OK      = 3'd0,
        ST_OVER    = 3'd1,
        ST_UNDER   = 3'd2,
        ST_DIVZERO = 3'd3,
        ST_UNKNOWN = 3'd4
    } status_t;

    // One operation in flight. hi and lo form the working pair of the
    // shift-and-add multiply or the restoring divide; mc is the
    // multiplicand or divisor magnitude.
    typedef struct packed {
        op_t                  op;
        status_t              status;
        logic                 neg;
        logic                 a_neg;
        logic [DataWidth:0]   hi;
        logic [DataWidth-1:0] lo;
        logic [DataWidth-1:0] mc;
    } csa_item_t;

endpackage

### rtl/core/csa_front.sv
`timescale 1ns / 1ps

module csa_front
    import csa_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 advance,
    input  logic                 in_valid,
    input  logic [DataWidth-1:0] operand_a,
    input  logic [DataWidth-1:0] operand_b,
    input  logic [2:0]           command,
    output logic                 valid,
    output csa_item_t            item
);

    logic      valid_reg;
    csa_item_t item_reg;
    csa_item_t item_next;

    logic                 a_neg;
    logic                 b_neg;
    logic [DataWidth-1:0] a_mag;
    logic [DataWidth-1:0] b_mag;
    logic [DataWidth:0]   sum;

    always_comb
    begin
        a_neg = operand_a[DataWidth-1];
        b_neg = operand_b[DataWidth-1];
        a_mag = a_neg ? (~operand_a + 1'b1) : operand_a;
        b_mag = b_neg ? (~operand_b + 1'b1) : operand_b;
        if (command == OP_SUB)
        begin
            sum = {a_neg, operand_a} - {b_neg, operand_b};
        end
        else
        begin
            sum = {a_neg, operand_a} + {b_neg, operand_b};
        end

        item_next        = '0;
        item_next.status = ST_OK;
        item_next.a_neg  = a_neg;
        item_next.neg    = a_neg ^ b_neg;
        unique case (command)
            OP_ADD, OP_SUB:
            begin
                item_next.op = op_t'(command);
                item_next.lo = sum[DataWidth-1:0];
                // Sign of the wide sum tells the direction of the overflow.
                if (sum[DataWidth] != sum[DataWidth-1])
                begin
                    item_next.status = sum[DataWidth] ? ST_UNDER : ST_OVER;
                end
            end
            OP_MUL:
            begin
                item_next.op = OP_MUL;
                item_next.lo = b_mag;
                item_next.mc = a_mag;
            end
            OP_DIV, OP_MOD:
            begin
                item_next.op = op_t'(command);
                item_next.lo = a_mag;
                item_next.mc = b_mag;
                if (operand_b == '0)
                begin
                    item_next.status = ST_DIVZERO;
                end
            end
            default:
            begin
                item_next.op     = OP_ADD;
                item_next.status = ST_UNKNOWN;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            item_reg <= item_next;
        end
    end

    assign valid = valid_reg;
    assign item  = item_reg;

endmodule

### rtl/core/csa_cell.sv
`timescale 1ns / 1ps

module csa_cell
    import csa_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      advance,
    input  logic      prev_valid,
    input  csa_item_t prev_item,
    output logic      valid,
    output csa_item_t item
);

    logic      valid_reg;
    csa_item_t item_reg;
    csa_item_t item_next;

    logic [DataWidth:0] sum;
    logic [DataWidth:0] shifted;
    logic [DataWidth:0] diff;

    // One multiplier bit or one quotient bit per cell.
    always_comb
    begin
        item_next = prev_item;
        sum       = prev_item.hi + (prev_item.lo[0] ? {1'b0, prev_item.mc} : '0);
        shifted   = {prev_item.hi[DataWidth-1:0], prev_item.lo[DataWidth-1]};
        diff      = shifted - {1'b0, prev_item.mc};
        unique case (prev_item.op)
            OP_MUL:
            begin
                item_next.hi = {1'b0, sum[DataWidth:1]};
                item_next.lo = {sum[0], prev_item.lo[DataWidth-1:1]};
            end
            OP_DIV, OP_MOD:
            begin
                item_next.hi = diff[DataWidth] ? shifted : diff;
                item_next.lo = {prev_item.lo[DataWidth-2:0], ~diff[DataWidth]};
            end
            default:
            begin
                item_next = prev_item;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            valid_reg <= prev_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            item_reg <= item_next;
        end
    end

    assign valid = valid_reg;
    assign item  = item_reg;

endmodule

### rtl/core/csa_back.sv
`timescale 1ns / 1ps

module csa_back
    import csa_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 advance,
    input  logic                 prev_valid,
    input  csa_item_t            prev_item,
    output logic                 out_valid,
    output logic [DataWidth-1:0] result,
    output logic [2:0]           status
);

    logic                 valid_reg;
    logic [DataWidth-1:0] result_reg;
    logic [DataWidth-1:0] result_next;
    status_t              status_reg;
    status_t              status_next;
    logic [DataWidth-1:0] rem;

    always_comb
    begin
        status_next = prev_item.status;
        result_next = '0;
        rem         = prev_item.hi[DataWidth-1:0];
        unique case (prev_item.op)
            OP_ADD, OP_SUB:
            begin
                result_next = prev_item.lo;
            end
            OP_MUL:
            begin
                // Magnitude must fit below 2^63, or equal it for a negative product.
                if ((prev_item.hi[DataWidth-1:0] != '0) ||
                    (prev_item.lo[DataWidth-1] &&
                     (!prev_item.neg || (prev_item.lo[DataWidth-2:0] != '0))))
                begin
                    status_next = prev_item.neg ? ST_UNDER : ST_OVER;
                end
                else
                begin
                    result_next = prev_item.neg ? (~prev_item.lo + 1'b1) : prev_item.lo;
                end
            end
            OP_DIV:
            begin
                // A zero divisor keeps its own status over the quotient check.
                if ((prev_item.status == ST_OK) && !prev_item.neg &&
                    prev_item.lo[DataWidth-1])
                begin
                    status_next = ST_OVER;
                end
                else
                begin
                    result_next = prev_item.neg ? (~prev_item.lo + 1'b1) : prev_item.lo;
                end
            end
            OP_MOD:
            begin
                result_next = (prev_item.a_neg && (rem != '0)) ? (prev_item.mc - rem) : rem;
            end
            default:
            begin
                result_next = '0;
            end
        endcase
        if (status_next != ST_OK)
        begin
            result_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            valid_reg <= prev_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            result_reg <= result_next;
            status_reg <= status_next;
        end
    end

    assign out_valid = valid_reg;
    assign result    = result_reg;
    assign status    = status_reg;

endmodule

### rtl/core/checked_signed_alu_unit.sv
`timescale 1ns / 1ps
// Channel  | Handshake            | Payload
// ---------+----------------------+-------------------------------------------
// in       | in_valid / in_ready  | operand_a[63:0], operand_b[63:0], command[2:0]
// out      | out_valid / out_ready| result[63:0], status[2:0]
//
// A new beat is taken every cycle unless the output stalls; each beat passes
// through one decode register, one cell per operand bit, one result register.
// The latency is set by the chain of cells: each cell does one step of the
// shift-and-add multiply or of the restoring divide.
// The whole chain moves as one; it holds while a result waits at the output.
// Reset clears all valid bits; data registers are not reset.

module checked_signed_alu_unit
    import csa_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic [DataWidth-1:0] operand_a,
    input  logic [DataWidth-1:0] operand_b,
    input  logic [2:0]           command,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic [DataWidth-1:0] result,
    output logic [2:0]           status
);

    // The chain advances unless the output register holds an untaken beat.
    logic advance;
    assign advance  = !out_valid || out_ready;
    assign in_ready = advance;

    logic      valid_chain [DataWidth+1];
    csa_item_t item_chain  [DataWidth+1];

    csa_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .advance   (advance),
        .in_valid  (in_valid),
        .operand_a (operand_a),
        .operand_b (operand_b),
        .command   (command),
        .valid     (valid_chain[0]),
        .item      (item_chain[0])
    );

    // Each cell takes the work from its left neighbor and hands it right.
    for (genvar i = 0; i < DataWidth; i++)
    begin : g_cell
        csa_cell u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .advance    (advance),
            .prev_valid (valid_chain[i]),
            .prev_item  (item_chain[i]),
            .valid      (valid_chain[i+1]),
            .item       (item_chain[i+1])
        );
    end

    csa_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .advance    (advance),
        .prev_valid (valid_chain[DataWidth]),
        .prev_item  (item_chain[DataWidth]),
        .out_valid  (out_valid),
        .result     (result),
        .status     (status)
    );

    // A flagged result always carries a zero value.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (status != ST_OK)) |-> (result == '0))
        else $error("nonzero result with error status");

    // Only defined status codes leave the block.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (status == ST_OK || status == ST_OVER || status == ST_UNDER ||
                       status == ST_DIVZERO || status == ST_UNKNOWN))
        else $error("undefined status code");

    // A stalled output freezes the chain, so the input must be closed.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |-> !in_ready)
        else $error("input open while output stalled");

    // A beat taken at the output with nothing behind it leaves it empty.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_ready && !valid_chain[DataWidth]) |=> !out_valid)
        else $error("output beat repeated");

endmodule
